@@ hdl/wud_pkg.sv @@
`default_nettype none
package wud_pkg;
   localparam int LIMB_WIDTH = 64;
   localparam int LIMB_COUNT_DEFAULT = 2;
endpackage
`default_nettype wire

@@ hdl/wide_unsigned_divider.sv @@
`default_nettype none
// Wide unsigned divider, LIMB_COUNT x 64 bits.
// Input channel req_: one dividend limb and one divisor limb per request,
// least significant limb first. After LIMB_COUNT requests the block divides.
// Output channel rsp_: LIMB_COUNT results (quotient limb, remainder limb),
// least significant first, rsp_last_result on the top limb. A zero divisor
// gives zeros with rsp_divide_by_zero set on every result of the run.
// The limbs are read from the limb memories into working registers, then
// one radix-2 restoring step per cycle, one per quotient bit (no steps for a
// zero divisor), then one result per cycle while not stalled. The bit-serial
// step loop takes up most of a run.
// Requests are taken only while collecting limbs; req_stall is high during
// the load, the division and while results are emitted. A stalled result holds.
// reset is synchronous, active high; it returns the block to collecting.
module wide_unsigned_divider #(
   parameter int LIMB_COUNT = wud_pkg::LIMB_COUNT_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [wud_pkg::LIMB_WIDTH-1:0] req_dividend_limb,
   input  wire logic [wud_pkg::LIMB_WIDTH-1:0] req_divisor_limb,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [wud_pkg::LIMB_WIDTH-1:0]     rsp_quotient_limb,
   output logic [wud_pkg::LIMB_WIDTH-1:0]     rsp_remainder_limb,
   output logic                               rsp_divide_by_zero,
   output logic                               rsp_last_result
);
   import wud_pkg::*;
   localparam int W  = LIMB_COUNT * LIMB_WIDTH;
   localparam int AW = (LIMB_COUNT > 1) ? $clog2(LIMB_COUNT) : 1;
   localparam int SW = $clog2(W + 1);

   localparam logic [1:0] S_COLLECT = 2'd0;
   localparam logic [1:0] S_LOAD    = 2'd1;
   localparam logic [1:0] S_DIVIDE  = 2'd2;
   localparam logic [1:0] S_EMIT    = 2'd3;

   logic [1:0]    state_ff, state_in;
   logic [AW-1:0] cnt_ff, cnt_in;
   logic [AW-1:0] rd_addr;
   logic [SW-1:0] step_ff, step_in;
   logic [W-1:0]  num_ff, num_in, den_ff, den_in, rem_ff, rem_in, quo_ff, quo_in;
   logic          dbz_ff, dbz_in;
   logic [LIMB_WIDTH-1:0] dvd_rd, dvs_rd;
   logic          wr_en, req_take, rsp_take, last_limb;
   logic [W:0]    shifted, diff;

   assign req_stall = (state_ff != S_COLLECT);
   assign req_take  = req_valid && !req_stall;
   assign wr_en     = req_take;
   assign rsp_take  = rsp_valid && !rsp_stall;
   assign last_limb = (cnt_ff == AW'(LIMB_COUNT - 1));
   assign rd_addr   = cnt_ff;

   wud_limb_ram #(.DEPTH(LIMB_COUNT), .WIDTH(LIMB_WIDTH)) u_dividend (
      .clock(clock), .wr_en(wr_en), .wr_addr(cnt_ff), .wr_data(req_dividend_limb),
      .rd_addr(rd_addr), .rd_data(dvd_rd));
   wud_limb_ram #(.DEPTH(LIMB_COUNT), .WIDTH(LIMB_WIDTH)) u_divisor (
      .clock(clock), .wr_en(wr_en), .wr_addr(cnt_ff), .wr_data(req_divisor_limb),
      .rd_addr(rd_addr), .rd_data(dvs_rd));

   assign shifted = {rem_ff, num_ff[W-1]};
   assign diff    = shifted - {1'b0, den_ff};

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      step_in  = step_ff;
      num_in   = num_ff;
      den_in   = den_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      dbz_in   = dbz_ff;
      unique case (state_ff)
         S_COLLECT: begin
            if (req_take) begin
               if (last_limb) begin
                  cnt_in   = '0;
                  state_in = S_LOAD;
               end else begin
                  cnt_in = cnt_ff + AW'(1);
               end
            end
         end
         S_LOAD: begin
            // read data for the previously presented address arrives now; shift it in at the top
            if (step_ff != '0) begin
               num_in = W'({dvd_rd, num_ff} >> LIMB_WIDTH);
               den_in = W'({dvs_rd, den_ff} >> LIMB_WIDTH);
            end
            if (step_ff == SW'(LIMB_COUNT)) begin
               step_in  = SW'(W);
               rem_in   = '0;
               quo_in   = '0;
               cnt_in   = '0;
               state_in = S_DIVIDE;
            end else begin
               step_in = step_ff + SW'(1);
               if (!last_limb) begin
                  cnt_in = cnt_ff + AW'(1);
               end
            end
         end
         S_DIVIDE: begin
            if (step_ff == SW'(W)) begin
               dbz_in = (den_ff == '0);
            end
            if (den_ff == '0) begin
               rem_in   = '0;
               quo_in   = '0;
               step_in  = '0;
               state_in = S_EMIT;
            end else begin
               num_in = {num_ff[W-2:0], 1'b0};
               if (shifted[W] || !diff[W]) begin
                  rem_in = diff[W-1:0];
                  quo_in = {quo_ff[W-2:0], 1'b1};
               end else begin
                  rem_in = shifted[W-1:0];
                  quo_in = {quo_ff[W-2:0], 1'b0};
               end
               step_in = step_ff - SW'(1);
               if (step_ff == SW'(1)) begin
                  state_in = S_EMIT;
               end
            end
         end
         S_EMIT: begin
            if (rsp_take) begin
               rem_in = rem_ff >> LIMB_WIDTH;
               quo_in = quo_ff >> LIMB_WIDTH;
               if (last_limb) begin
                  cnt_in   = '0;
                  state_in = S_COLLECT;
               end else begin
                  cnt_in = cnt_ff + AW'(1);
               end
            end
         end
         default: state_in = S_COLLECT;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_COLLECT;
         cnt_ff   <= '0;
         step_ff  <= '0;
         dbz_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         step_ff  <= (state_ff == S_COLLECT) ? '0 : step_in;
         dbz_ff   <= dbz_in;
      end
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign rsp_valid          = (state_ff == S_EMIT);
   assign rsp_quotient_limb  = quo_ff[LIMB_WIDTH-1:0];
   assign rsp_remainder_limb = rem_ff[LIMB_WIDTH-1:0];
   assign rsp_divide_by_zero = dbz_ff;
   assign rsp_last_result    = last_limb;
endmodule
`default_nettype wire

@@ hdl/wud_limb_ram.sv @@
`default_nettype none
module wud_limb_ram #(
   parameter int DEPTH = 2,
   parameter int WIDTH = 64
) (
   input  wire logic                                       clock,
   input  wire logic                                       wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                           wr_data,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                           rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire
